@@ sv/adfd_pkg.sv @@
// Shared types and constants for the API frame deframer.
`timescale 1ns / 1ps

package adfd_pkg;

	// Default payload capacity in bytes
	localparam int MAX_PAYLOAD_DEF = 256;

	localparam logic [7:0] START_DELIM = 8'h7E;

	// Position codes; data positions run from POS_DATA upwards
	localparam int POS_HUNT   = 0;
	localparam int POS_LEN_HI = 1;
	localparam int POS_LEN_LO = 2;
	localparam int POS_KIND   = 3;
	localparam int POS_DATA   = 4;

	// Result status codes
	localparam logic [2:0] ST_BUSY     = 3'd0;
	localparam logic [2:0] ST_DONE     = 3'd1;
	localparam logic [2:0] ST_CSUM_ERR = 3'd2;
	localparam logic [2:0] ST_ZERO_LEN = 3'd3;
	localparam logic [2:0] ST_TOO_LONG = 3'd4;

	// Frame header state carried from byte to byte
	typedef struct packed {
		logic [15:0] length;
		logic [7:0]  kind;
		logic [7:0]  sum;
	} frame_state_t;

	// One result item
	typedef struct packed {
		logic [2:0]  status;
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic [7:0]  payload_index;
		logic [7:0]  frame_kind;
		logic [15:0] frame_length;
	} frame_result_t;

endpackage

@@ sv/api_frame_deframer.sv @@
// Top level of the API frame deframer: input register, frame logic, result register.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | sink      | in_valid / in_ready   | rx_byte
//  out     | source    | out_valid / out_ready | status, payload_valid, payload_byte,
//          |           |                       | payload_index, frame_kind, frame_length
//
// One byte per clock sustained while out_ready stays high; each byte gives exactly one result transfer.
// Each byte is held first in the input register, then in the result register.
// The frame state is updated as a byte moves from input register to result register.
// A stalled output holds its result; the input register still takes one more byte,
// and in_ready drops only when both registers are full and out_ready is low.
// arst_n clears the hunt position, header state and both valid flags.
`timescale 1ns / 1ps

module api_frame_deframer #(
	parameter int MAX_PAYLOAD = adfd_pkg::MAX_PAYLOAD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic        payload_valid,
	output logic [7:0]  payload_byte,
	output logic [7:0]  payload_index,
	output logic [7:0]  frame_kind,
	output logic [15:0] frame_length
);
	import adfd_pkg::*;

	localparam int POS_W = $clog2(MAX_PAYLOAD + 5);

	// input register
	logic          valid_s1;
	logic [7:0]    byte_s1;
	// result register
	logic          valid_s2;
	frame_result_t res_s2;
	// frame state
	logic [POS_W-1:0] pos_q;
	frame_state_t     st_q;

	logic [POS_W-1:0] pos_nxt;
	frame_state_t     st_nxt;
	frame_result_t    res;
	logic             adv;

	// a byte moves on when the result register is free or being emptied
	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	adfd_step #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_step (
		.pos     (pos_q),
		.st      (st_q),
		.rx_byte (byte_s1),
		.pos_nxt (pos_nxt),
		.st_nxt  (st_nxt),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			pos_q    <= '0;
			st_q     <= '0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv) begin
				valid_s2 <= 1'b1;
				pos_q    <= pos_nxt;
				st_q     <= st_nxt;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			byte_s1 <= rx_byte;
		if (adv)
			res_s2 <= res;
	end

	assign out_valid     = valid_s2;
	assign status        = res_s2.status;
	assign payload_valid = res_s2.payload_valid;
	assign payload_byte  = res_s2.payload_byte;
	assign payload_index = res_s2.payload_index;
	assign frame_kind    = res_s2.frame_kind;
	assign frame_length  = res_s2.frame_length;

	// payload bytes never carry an end-of-frame status
	a_pay_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.payload_valid |-> res_s2.status == ST_BUSY)
		else $error("payload byte with non-busy status");

	// payload index stays inside the capacity
	a_pay_idx: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.payload_valid |-> 17'(res_s2.payload_index) < 17'(MAX_PAYLOAD))
		else $error("payload index beyond capacity");

	// position never runs past the checksum byte of a longest frame
	a_pos_max: assert property (@(posedge clk) disable iff (!arst_n)
		17'(pos_q) <= 17'(MAX_PAYLOAD) + 17'd4)
		else $error("frame position out of range");

	// a byte leaving the input register lands in the result register
	a_adv: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("result lost on advance");

	// the hunt position is left only on a start delimiter
	a_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		adv && pos_q == POS_W'(POS_HUNT) && byte_s1 != START_DELIM
			|=> pos_q == POS_W'(POS_HUNT))
		else $error("hunt left without delimiter");

endmodule

@@ sv/adfd_step.sv @@
// Byte-wise next-state and result logic of the frame deframer.
`timescale 1ns / 1ps

module adfd_step #(
	parameter int MAX_PAYLOAD = adfd_pkg::MAX_PAYLOAD_DEF,
	localparam int POS_W = $clog2(MAX_PAYLOAD + 5)
) (
	input  logic [POS_W-1:0]           pos,
	input  adfd_pkg::frame_state_t     st,
	input  logic [7:0]                 rx_byte,
	output logic [POS_W-1:0]           pos_nxt,
	output adfd_pkg::frame_state_t     st_nxt,
	output adfd_pkg::frame_result_t    res
);
	import adfd_pkg::*;

	logic [15:0]      len_full;
	logic             too_long;
	logic             in_payload;
	logic [POS_W-1:0] pidx;

	assign len_full   = {st.length[15:8], rx_byte};
	assign too_long   = 17'(len_full) > (17'(MAX_PAYLOAD) + 17'd1);
	assign in_payload = 17'(pos) < (17'(st.length) + 17'(POS_KIND));
	assign pidx       = pos - POS_W'(POS_DATA);

	always_comb begin
		pos_nxt = pos;
		st_nxt  = st;
		res.status        = ST_BUSY;
		res.payload_valid = 1'b0;
		res.payload_byte  = 8'd0;
		res.payload_index = 8'd0;
		unique case (pos)
			POS_W'(POS_HUNT): begin
				if (rx_byte == START_DELIM)
					pos_nxt = POS_W'(POS_LEN_HI);
			end
			POS_W'(POS_LEN_HI): begin
				st_nxt.length = {rx_byte, 8'd0};
				pos_nxt       = POS_W'(POS_LEN_LO);
			end
			POS_W'(POS_LEN_LO): begin
				st_nxt.length = len_full;
				if (too_long) begin
					res.status = ST_TOO_LONG;
					pos_nxt    = POS_W'(POS_HUNT);
				end else begin
					pos_nxt = POS_W'(POS_KIND);
				end
			end
			POS_W'(POS_KIND): begin
				st_nxt.kind = rx_byte;
				st_nxt.sum  = rx_byte;
				pos_nxt     = POS_W'(POS_DATA);
			end
			default: begin
				if (st.length == 16'd0) begin
					res.status = ST_ZERO_LEN;
					pos_nxt    = POS_W'(POS_HUNT);
				end else if (in_payload) begin
					res.payload_valid = 1'b1;
					res.payload_byte  = rx_byte;
					res.payload_index = 8'(pidx);
					st_nxt.sum        = st.sum + rx_byte;
					pos_nxt           = pos + POS_W'(1);
				end else begin
					// checksum byte closes the frame
					res.status = (8'(st.sum + rx_byte + 8'd1) == 8'd0) ? ST_DONE : ST_CSUM_ERR;
					pos_nxt    = POS_W'(POS_HUNT);
				end
			end
		endcase
		res.frame_kind   = st_nxt.kind;
		res.frame_length = st_nxt.length;
	end

endmodule
